FILE: rtl/crcac_pkg.sv
`default_nettype none

package crcac_pkg;

  localparam int ByteW = 8;
  localparam int CrcW = 16;
  localparam int CfgIdxW = 1;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegPoly = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPreset = 1'd1;

  localparam logic [CrcW-1:0] PolyReset = 16'h1021;
  localparam logic [CrcW-1:0] PresetReset = 16'hFFFF;

  // result queue
  localparam int ResultDepth = 4;
  localparam int ResultPtrW = $clog2(ResultDepth);
  localparam int ResultCntW = $clog2(ResultDepth + 1);

  typedef enum logic {
    OpGenerate = 1'b0,
    OpCheck    = 1'b1
  } op_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_verdict;
    logic             crc_ok;
    logic             end_of_run;
  } result_t;

  // results written into the queue in one cycle: zero, one or two
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // reflected crc update, lsb of the byte first
  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc_in,
                                                input logic [ByteW-1:0] byte_in,
                                                input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = crc_in;
    for (int b = 0; b < ByteW; b++) begin
      fb = crc[0] ^ byte_in[b];
      crc = {1'b0, crc[CrcW-1:1]};
      if (fb) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/crcac_if.sv
`default_nettype none

interface crcac_msg_if;
  logic                         valid;
  logic                         ready;
  logic [crcac_pkg::ByteW-1:0]  data_byte;
  logic                         first_byte;
  logic                         last_byte;
  logic                         opcode;

  modport source(output valid, output data_byte, output first_byte, output last_byte,
                 output opcode, input ready);
  modport sink(input valid, input data_byte, input first_byte, input last_byte,
               input opcode, output ready);
endinterface

interface crcac_res_if;
  logic                         valid;
  logic                         ready;
  logic [crcac_pkg::ByteW-1:0]  out_byte;
  logic                         is_verdict;
  logic                         crc_ok;
  logic                         end_of_run;

  modport source(output valid, output out_byte, output is_verdict, output crc_ok,
                 output end_of_run, input ready);
  modport sink(input valid, input out_byte, input is_verdict, input crc_ok,
               input end_of_run, output ready);
endinterface

interface crcac_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [crcac_pkg::CfgIdxW-1:0] index;
  logic [crcac_pkg::CrcW-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/crc16_append_and_check_top.sv
`default_nettype none

// reflected crc-16 with programmable polynomial and preset. message bytes enter on msg,
// one per transfer, and the block takes one byte every cycle while the result queue has
// room for the held byte's results: each byte is registered, folded lsb first through an
// unrolled 8-step update while it is held in the input register, and any results land in
// a four-entry result queue, which registers them before they show on the result channel.
// a byte marked first_byte reloads the running crc from the preset register; no final
// xor is applied. on a byte marked last_byte, opcode 0 (generate) yields two result
// transfers, crc low byte then high byte, and opcode 1 (check) yields one verdict with
// crc_ok high when the crc over the whole message, its two crc bytes included, is zero.
// the result channel moves one transfer per cycle, so a steady stream of one-byte
// generate messages is held back by the result side; otherwise the rate is one byte per
// cycle as long as the result side keeps up. registers (cfg index 0 polynomial, reset
// 0x1021; index 1 preset, reset 0xffff) are always ready and should be written only
// while no message is in flight; a write does not touch the running crc.
module crc16_append_and_check_top (
  input  logic         clk,
  input  logic         rst,
  crcac_msg_if.sink    msg,
  crcac_res_if.source  result,
  crcac_cfg_if.sink    cfg
);

  logic [crcac_pkg::CrcW-1:0]        poly;
  logic [crcac_pkg::CrcW-1:0]        preset;
  logic [crcac_pkg::ResultCntW-1:0]  free_slots;
  crcac_pkg::push_t                  push;

  // polynomial and preset registers
  crcac_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .poly   (poly),
    .preset (preset)
  );

  // input register, running crc and result forming; a byte leaves the input
  // register only when the queue has room for all of its results
  crcac_core u_core (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .poly       (poly),
    .preset     (preset),
    .free_slots (free_slots),
    .push       (push)
  );

  // result queue, decouples a stalled result channel from the byte stream
  crcac_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .free_slots (free_slots),
    .result     (result)
  );

endmodule

`default_nettype wire

FILE: rtl/crcac_cfg_regs.sv
`default_nettype none

module crcac_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  crcac_cfg_if.sink                   cfg,
  output logic [crcac_pkg::CrcW-1:0]  poly,
  output logic [crcac_pkg::CrcW-1:0]  preset
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly   <= crcac_pkg::PolyReset;
      preset <= crcac_pkg::PresetReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        crcac_pkg::RegPoly:   poly   <= cfg.data;
        crcac_pkg::RegPreset: preset <= cfg.data;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crcac_core.sv
`default_nettype none

module crcac_core (
  input  logic                              clk,
  input  logic                              rst,
  crcac_msg_if.sink                         msg,
  input  logic [crcac_pkg::CrcW-1:0]        poly,
  input  logic [crcac_pkg::CrcW-1:0]        preset,
  input  logic [crcac_pkg::ResultCntW-1:0]  free_slots,
  output crcac_pkg::push_t                  push
);

  // input register
  logic                        stage_valid;
  logic [crcac_pkg::ByteW-1:0] stage_byte;
  logic                        stage_first;
  logic                        stage_last;
  crcac_pkg::op_t              stage_op;

  logic [crcac_pkg::CrcW-1:0]  running_crc;
  logic [crcac_pkg::CrcW-1:0]  crc_base;
  logic [crcac_pkg::CrcW-1:0]  crc_next;
  logic [1:0]                  need;
  logic                        advance;
  logic                        take;

  always_comb begin
    crc_base = stage_first ? preset : running_crc;
    crc_next = crcac_pkg::crc_fold(crc_base, stage_byte, poly);

    if (!stage_last) begin
      need = 2'd0;
    end else if (stage_op == crcac_pkg::OpCheck) begin
      need = 2'd1;
    end else begin
      need = 2'd2;
    end

    advance = stage_valid && (free_slots >= crcac_pkg::ResultCntW'(need));
  end

  assign msg.ready = !stage_valid || advance;
  assign take = msg.valid && msg.ready;

  always_comb begin
    push.count = advance ? need : 2'd0;
    if (stage_op == crcac_pkg::OpCheck) begin
      push.first.out_byte   = '0;
      push.first.is_verdict = 1'b1;
      push.first.crc_ok     = (crc_next == '0);
      push.first.end_of_run = 1'b1;
    end else begin
      push.first.out_byte   = crc_next[crcac_pkg::ByteW-1:0];
      push.first.is_verdict = 1'b0;
      push.first.crc_ok     = 1'b0;
      push.first.end_of_run = 1'b0;
    end
    push.second.out_byte   = crc_next[crcac_pkg::CrcW-1:crcac_pkg::ByteW];
    push.second.is_verdict = 1'b0;
    push.second.crc_ok     = 1'b0;
    push.second.end_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      running_crc <= crcac_pkg::PresetReset;
    end else begin
      if (take) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        running_crc <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_byte  <= msg.data_byte;
      stage_first <= msg.first_byte;
      stage_last  <= msg.last_byte;
      stage_op    <= crcac_pkg::op_t'(msg.opcode);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crcac_result_fifo.sv
`default_nettype none

module crcac_result_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  crcac_pkg::push_t                  push,
  output logic [crcac_pkg::ResultCntW-1:0]  free_slots,
  crcac_res_if.source                       result
);

  crcac_pkg::result_t                   mem [crcac_pkg::ResultDepth];
  logic [crcac_pkg::ResultPtrW-1:0]     wr_ptr;
  logic [crcac_pkg::ResultPtrW-1:0]     rd_ptr;
  logic [crcac_pkg::ResultCntW-1:0]     count;
  logic [crcac_pkg::ResultCntW-1:0]     count_next;
  logic                                 pop;
  crcac_pkg::result_t                   head;

  assign free_slots = crcac_pkg::ResultCntW'(crcac_pkg::ResultDepth) - count;

  assign head              = mem[rd_ptr];
  assign result.valid      = (count != '0);
  assign result.out_byte   = head.out_byte;
  assign result.is_verdict = head.is_verdict;
  assign result.crc_ok     = head.crc_ok;
  assign result.end_of_run = head.end_of_run;

  assign pop = result.valid && result.ready;

  always_comb begin
    count_next = count + crcac_pkg::ResultCntW'(push.count)
                 - crcac_pkg::ResultCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + crcac_pkg::ResultPtrW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // up to two entries written per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[crcac_pkg::ResultPtrW'(wr_ptr + 1'b1)] <= push.second;
    end
  end

endmodule

`default_nettype wire
